// ----- rtl/fpsc_pkg.sv -----
// fpsc_pkg: shared types, constants and rule tables for the fuzzy pd steering core
// no dependencies
package fpsc_pkg;

  localparam int ErrW = 12;
  localparam int ModeW = 3;
  localparam int GainW = 9;
  localparam int ServoW = 16;
  localparam int CmdW = 19;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 63;

  localparam int ErrorLimit = 36;
  localparam int DerivLimit = 15;
  localparam int DiffLimit = 400;
  localparam int ServoMid = 1500;
  localparam int ServoMin = 1100;
  localparam int ServoMax = 1900;

  localparam logic [CfgIdxW-1:0] CFG_P_BP = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_D_BP = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KP_LV = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KD_LV = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MODE_G = 3'd4;

  localparam logic [ModeW-1:0] MODE_RING_RUN = 3'd1;
  localparam logic [ModeW-1:0] MODE_RING_OUT = 3'd2;
  localparam logic [ModeW-1:0] MODE_RING_IN = 3'd3;
  localparam logic [ModeW-1:0] MODE_OBSTACLE = 3'd4;
  localparam logic [ModeW-1:0] MODE_PARKING = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_FUZZ,
    ST_DIV,
    ST_RULE,
    ST_MAC,
    ST_ROUND,
    ST_TERM,
    ST_SERVO,
    ST_CMD,
    ST_OUT
  } state_t;

  function automatic logic [2:0] kp_rule(input logic [2:0] p, input logic [2:0] d);
    logic [2:0] t [49];
    t = '{3'd6,3'd5,3'd4,3'd3,3'd2,3'd0,3'd0, 3'd5,3'd4,3'd3,3'd2,3'd1,3'd0,3'd1,
          3'd4,3'd3,3'd2,3'd1,3'd0,3'd1,3'd2, 3'd3,3'd2,3'd1,3'd0,3'd1,3'd2,3'd3,
          3'd2,3'd1,3'd0,3'd1,3'd2,3'd3,3'd4, 3'd1,3'd0,3'd1,3'd2,3'd3,3'd4,3'd5,
          3'd0,3'd0,3'd2,3'd3,3'd4,3'd5,3'd6};
    return t[6'(p) * 6'd7 + 6'(d)];
  endfunction

  function automatic logic [2:0] kd_rule(input logic [2:0] p, input logic [2:0] d);
    logic [2:0] t [49];
    t = '{3'd2,3'd2,3'd6,3'd5,3'd6,3'd4,3'd2, 3'd1,3'd2,3'd5,3'd4,3'd3,3'd1,3'd0,
          3'd0,3'd1,3'd3,3'd3,3'd1,3'd1,3'd0, 3'd0,3'd1,3'd1,3'd1,3'd1,3'd1,3'd0,
          3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0, 3'd5,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,
          3'd6,3'd4,3'd4,3'd3,3'd3,3'd1,3'd1};
    return t[6'(p) * 6'd7 + 6'(d)];
  endfunction

endpackage

// ----- rtl/fpsc_if.sv -----
// fpsc stream and config interfaces
// depends on fpsc_pkg
interface fpsc_in_if;
  logic valid;
  logic ready;
  logic signed [fpsc_pkg::ErrW-1:0] steer_error;
  logic [fpsc_pkg::ModeW-1:0] drive_mode;
  modport source (output valid, steer_error, drive_mode, input ready);
  modport sink (input valid, steer_error, drive_mode, output ready);
endinterface

interface fpsc_out_if;
  logic valid;
  logic ready;
  logic [fpsc_pkg::ServoW-1:0] servo_pwm;
  logic [fpsc_pkg::CmdW-1:0] steer_command;
  logic [fpsc_pkg::GainW-1:0] kp_gain;
  logic [fpsc_pkg::GainW-1:0] kd_gain;
  modport source (output valid, servo_pwm, steer_command, kp_gain, kd_gain, input ready);
  modport sink (input valid, servo_pwm, steer_command, kp_gain, kd_gain, output ready);
endinterface

interface fpsc_cfg_if;
  logic valid;
  logic ready;
  logic [fpsc_pkg::CfgIdxW-1:0] index;
  logic [fpsc_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/fuzzy_pd_steering_controller_core.sv -----
// fuzzy_pd_steering_controller_core: fuzzy self-tuning pd steering controller top level
// depends on fpsc_pkg and fpsc_if
//
// channel  dir  payload
// in_      in   steer_error, drive_mode
// out_     out  servo_pwm, steer_command, kp_gain, kd_gain
// cfg_     in   index, data (register write)
//
// a new word is taken only once the last result has left on out_ready; each word goes through:
// two restoring divides for the memberships, eight multiply-accumulate steps of
// one shared 9x18 multiplier with two rounding steps, then pd term, servo and command
// a membership outside the outer breakpoints skips its divide
// reset clears state and previous error, config to defaults; in_ready is low while a word
// is at work or while the result waits on out_ready; cfg_ready is always high
module fuzzy_pd_steering_controller_core (
  input logic clk,
  input logic rst_n,
  fpsc_in_if.sink in_ch,
  fpsc_out_if.source out_ch,
  fpsc_cfg_if.sink cfg_ch
);

  fpsc_pkg::state_t state_r, state_nxt;

  logic [23:0] p_bp_r, d_bp_r, mode_g_r;
  logic [62:0] kp_lv_r, kd_lv_r;

  logic signed [10:0] prev_r, err_r;
  logic signed [12:0] diff_r;
  logic [2:0] mode_r;

  // fuzzify: which=0 error, 1 change
  logic which_r;
  logic [2:0] pi_r, di_r;
  logic [8:0] pm_r, dm_r;
  logic [13:0] num_r;
  logic [12:0] den_r;
  logic [3:0] cnt_r;
  logic [8:0] quo_r;
  logic [21:0] rem_r;

  logic [2:0] k_r;
  logic [8:0] lvl_r;
  logic [17:0] wgt_r;
  logic [33:0] acc_r;
  logic [8:0] kp_r, kd_r;

  logic signed [31:0] term_r;
  logic [15:0] servo_r;
  logic [18:0] cmd_r;

  logic in_acc, cfg_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready = (state_r == fpsc_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == fpsc_pkg::ST_OUT);
  assign out_ch.servo_pwm = servo_r;
  assign out_ch.steer_command = cmd_r;
  assign out_ch.kp_gain = kp_r;
  assign out_ch.kd_gain = kd_r;

  function automatic logic signed [12:0] diff_clamp(input logic signed [12:0] d);
    logic signed [12:0] l;
    l = 13'(fpsc_pkg::DerivLimit * 16);
    if (d > l) return l;
    if (d < -l) return -l;
    return d;
  endfunction

  // breakpoint setup for the fuzzifier
  logic [23:0] bp;
  logic signed [12:0] x, pt [7];
  logic [2:0] seg, seg1;
  logic inside_lo, inside_hi;
  always_comb begin
    bp = which_r ? d_bp_r : p_bp_r;
    x = which_r ? diff_clamp(diff_r) : 13'(err_r);
    pt[0] = -$signed({1'b0, bp[7:0], 4'd0});
    pt[1] = -$signed({1'b0, bp[15:8], 4'd0});
    pt[2] = -$signed({1'b0, bp[23:16], 4'd0});
    pt[3] = '0;
    pt[4] = $signed({1'b0, bp[23:16], 4'd0});
    pt[5] = $signed({1'b0, bp[15:8], 4'd0});
    pt[6] = $signed({1'b0, bp[7:0], 4'd0});
    inside_lo = x > pt[0];
    inside_hi = x < pt[6];
    seg = 3'd5;
    for (int k = 5; k >= 0; k--) begin
      if (x < pt[k+1]) seg = 3'(k);
    end
    seg1 = seg + 3'd1;
  end

  // shared multiplier
  logic [2:0] rp, rd, sp, sd, ridx;
  logic [8:0] wa, wb;
  logic [8:0] mul_a;
  logic [17:0] mul_b;
  logic [26:0] mul_y;
  always_comb begin
    sp = (k_r[0] && pi_r < 3'd6) ? pi_r + 3'd1 : pi_r;
    sd = (k_r[1] && di_r < 3'd6) ? di_r + 3'd1 : di_r;
    wa = k_r[0] ? 9'(10'd256 - 10'(pm_r)) : pm_r;
    wb = k_r[1] ? 9'(10'd256 - 10'(dm_r)) : dm_r;
    rp = fpsc_pkg::kp_rule(sp, sd);
    rd = fpsc_pkg::kd_rule(sp, sd);
    ridx = k_r[2] ? rd : rp;
    mul_a = lvl_r;
    mul_b = wgt_r;
  end
  assign mul_y = 27'(mul_a) * 27'(mul_b);

  logic [62:0] lv_sel;
  assign lv_sel = k_r[2] ? kd_lv_r : kp_lv_r;

  // pd term pieces
  logic [12:0] kpx, kdx;
  always_comb begin
    kpx = 13'(kp_r);
    kdx = 13'(kd_r);
    unique case (mode_r)
      fpsc_pkg::MODE_RING_RUN: kpx = 13'(kp_r) + {1'b0, mode_g_r[7:0], 4'd0};
      fpsc_pkg::MODE_RING_OUT: kpx = 13'(kp_r) + 13'd240;
      fpsc_pkg::MODE_RING_IN: kpx = 13'(kp_r) + {1'b0, mode_g_r[15:8], 4'd0};
      fpsc_pkg::MODE_OBSTACLE: begin
        kpx = 13'(kp_r) + {1'b0, mode_g_r[23:16], 4'd0};
        kdx = 13'(kd_r) + 13'd16;
      end
      fpsc_pkg::MODE_PARKING: kpx = 13'(kp_r) + 13'd48;
      default: ;
    endcase
  end

  logic signed [31:0] tsum, tl;
  logic signed [31:0] vsum;
  logic [22:0] v23;
  always_comb begin
    tsum = 32'(err_r) * 32'($signed({1'b0, kpx})) + 32'(diff_r) * 32'($signed({1'b0, kdx}));
    tl = 32'(fpsc_pkg::DiffLimit * 256);
    vsum = 32'(fpsc_pkg::ServoMid * 256) - term_r;
    v23 = 23'(vsum[31:8]);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_bp_r <= 24'd660516;
      d_bp_r <= 24'd330255;
      kp_lv_r <= '0;
      kd_lv_r <= '0;
      mode_g_r <= 24'd7680;
    end else if (cfg_acc) begin
      unique case (cfg_ch.index)
        fpsc_pkg::CFG_P_BP: p_bp_r <= cfg_ch.data[23:0];
        fpsc_pkg::CFG_D_BP: d_bp_r <= cfg_ch.data[23:0];
        fpsc_pkg::CFG_KP_LV: kp_lv_r <= cfg_ch.data;
        fpsc_pkg::CFG_KD_LV: kd_lv_r <= cfg_ch.data;
        fpsc_pkg::CFG_MODE_G: mode_g_r <= cfg_ch.data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fpsc_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpsc_pkg::ST_IDLE: if (in_acc) state_nxt = fpsc_pkg::ST_CLAMP;
      fpsc_pkg::ST_CLAMP: state_nxt = fpsc_pkg::ST_FUZZ;
      fpsc_pkg::ST_FUZZ: begin
        if (inside_lo && inside_hi) state_nxt = fpsc_pkg::ST_DIV;
        else if (which_r) state_nxt = fpsc_pkg::ST_RULE;
      end
      fpsc_pkg::ST_DIV: if (cnt_r == 4'd8) state_nxt = which_r ? fpsc_pkg::ST_RULE
                                                               : fpsc_pkg::ST_FUZZ;
      fpsc_pkg::ST_RULE: state_nxt = fpsc_pkg::ST_MAC;
      fpsc_pkg::ST_MAC: state_nxt = (k_r[1:0] == 2'd3) ? fpsc_pkg::ST_ROUND
                                                        : fpsc_pkg::ST_RULE;
      fpsc_pkg::ST_ROUND: state_nxt = k_r[2] ? fpsc_pkg::ST_RULE : fpsc_pkg::ST_TERM;
      fpsc_pkg::ST_TERM: state_nxt = fpsc_pkg::ST_SERVO;
      fpsc_pkg::ST_SERVO: state_nxt = fpsc_pkg::ST_CMD;
      fpsc_pkg::ST_CMD: state_nxt = fpsc_pkg::ST_OUT;
      fpsc_pkg::ST_OUT: if (out_ch.ready) state_nxt = fpsc_pkg::ST_IDLE;
      default: state_nxt = fpsc_pkg::ST_IDLE;
    endcase
  end

  logic signed [10:0] ecl;
  logic signed [11:0] ein;
  always_comb begin
    ein = in_ch.steer_error;
    if (ein > 12'sd576) ecl = 11'sd576;
    else if (ein < -12'sd576) ecl = -11'sd576;
    else ecl = 11'(ein);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (state_r == fpsc_pkg::ST_CLAMP) begin
      prev_r <= err_r;
    end
    unique case (state_r)
      fpsc_pkg::ST_IDLE: if (in_acc) begin
        err_r <= ecl;
        mode_r <= in_ch.drive_mode;
        which_r <= 1'b0;
      end
      fpsc_pkg::ST_CLAMP: diff_r <= 13'(err_r) - 13'(prev_r);
      fpsc_pkg::ST_FUZZ: begin
        if (inside_lo && inside_hi) begin
          if (which_r) di_r <= seg; else pi_r <= seg;
          num_r <= 14'(pt[seg1] - x);
          den_r <= 13'(pt[seg1] - pt[seg]);
          quo_r <= '0;
          cnt_r <= '0;
          rem_r <= '0;
        end else begin
          if (which_r) begin
            di_r <= inside_lo ? 3'd6 : 3'd0; dm_r <= 9'd256; k_r <= '0; acc_r <= '0;
          end else begin
            pi_r <= inside_lo ? 3'd6 : 3'd0; pm_r <= 9'd256; which_r <= 1'b1;
          end
        end
      end
      fpsc_pkg::ST_DIV: begin
        // restoring divide of num*256 by den, one quotient bit a cycle
        begin
          logic [22:0] r2;
          logic [22:0] t;
          r2 = (cnt_r == 4'd0) ? 23'(num_r) : {rem_r, 1'b0};
          t = r2 - 23'(den_r);
          if (!t[22]) begin rem_r <= 22'(t); quo_r <= {quo_r[7:0], 1'b1}; end
          else begin rem_r <= 22'(r2); quo_r <= {quo_r[7:0], 1'b0}; end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd8) begin
            if (which_r) begin
              dm_r <= !t[22] ? {quo_r[7:0], 1'b1} : {quo_r[7:0], 1'b0};
              k_r <= '0; acc_r <= '0;
            end else begin
              pm_r <= !t[22] ? {quo_r[7:0], 1'b1} : {quo_r[7:0], 1'b0};
              which_r <= 1'b1;
            end
          end
        end
      end
      fpsc_pkg::ST_RULE: begin
        lvl_r <= 9'(lv_sel >> (9 * int'(ridx)));
        wgt_r <= 18'(wa) * 18'(wb);
      end
      fpsc_pkg::ST_MAC: begin
        acc_r <= acc_r + 34'(mul_y);
        k_r <= k_r + 3'd1;
      end
      fpsc_pkg::ST_ROUND: begin
        // k has already stepped past the group just summed
        if (k_r[2]) kp_r <= 9'((acc_r + 34'd32768) >> 16);
        else kd_r <= 9'((acc_r + 34'd32768) >> 16);
        acc_r <= '0;
      end
      fpsc_pkg::ST_TERM: term_r <= (tsum > tl) ? tl : ((tsum < -tl) ? -tl : tsum);
      fpsc_pkg::ST_SERVO: begin
        if (vsum < 0) servo_r <= 16'(fpsc_pkg::ServoMin);
        else if (v23 > 23'(fpsc_pkg::ServoMax)) servo_r <= 16'(fpsc_pkg::ServoMax);
        else if (v23 < 23'(fpsc_pkg::ServoMin)) servo_r <= 16'(fpsc_pkg::ServoMin);
        else servo_r <= 16'(v23);
      end
      // scale by 66 and divide by ten through a reciprocal exact for the whole 16-bit servo range
      fpsc_pkg::ST_CMD: cmd_r <= 19'((48'(servo_r) * 48'd66 * 48'd6710887) >> 26);
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r) == fpsc_pkg::ST_CMD)
    else $error("result without completed pipeline");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while result pending");
  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.servo_pwm >= 16'(fpsc_pkg::ServoMin) &&
                      out_ch.servo_pwm <= 16'(fpsc_pkg::ServoMax)))
    else $error("servo out of range");
`endif

endmodule

// ----- sim/tb_if_note.sv -----
// testbench support: a shared helper result type for the steering controller bench
// depends on fpsc_pkg
`timescale 1ns / 100ps
package tb_steer_pkg;

  typedef struct packed {
    logic [fpsc_pkg::ServoW-1:0] servo_pwm;
    logic [fpsc_pkg::CmdW-1:0] steer_command;
    logic [fpsc_pkg::GainW-1:0] kp_gain;
    logic [fpsc_pkg::GainW-1:0] kd_gain;
  } steer_result_t;
endpackage

// ----- sim/testbench.sv -----
// testbench for fuzzy_pd_steering_controller_core: directed table then random words,
// checked against an in-bench fuzzy pd predictor with random idling on both channels
// depends on fpsc_pkg, fpsc_if, tb_steer_pkg and the core
`timescale 1ns / 100ps
module testbench;

  localparam int IdleLimit = 20000;

  typedef struct {
    logic signed [fpsc_pkg::ErrW-1:0] err;
    logic [fpsc_pkg::ModeW-1:0] mode;
    bit known;
    logic [fpsc_pkg::ServoW-1:0] servo;
    logic [fpsc_pkg::GainW-1:0] kp;
    logic [fpsc_pkg::GainW-1:0] kd;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  always #2 clk = ~clk;

  fpsc_in_if in_ch();
  fpsc_out_if out_ch();
  fpsc_cfg_if cfg_ch();

  fuzzy_pd_steering_controller_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  logic [23:0] p_bp_reg, d_bp_reg, extra_reg;
  logic [62:0] kp_lv_reg, kd_lv_reg;
  int signed prev_err;
  tb_steer_pkg::steer_result_t steer_expected[$];
  bit fail_seen = 0;
  bit hold_out = 0;
  bit no_idle = 0;
  int quiet_cycles = 0;

  function automatic void bp_points(input logic [23:0] r, output int signed pt[7]);
    pt[6] = int'(r[7:0]) * 16;
    pt[5] = int'(r[15:8]) * 16;
    pt[4] = int'(r[23:16]) * 16;
    pt[3] = 0;
    pt[2] = -pt[4];
    pt[1] = -pt[5];
    pt[0] = -pt[6];
  endfunction

  function automatic void membership(input int signed x, input int signed pt[7],
                                     output int idx, output int mu);
    idx = 0;
    mu = 256;
    if (x > pt[0] && x < pt[6]) begin
      for (int k = 0; k < 6; k++) begin
        if (x < pt[k+1]) begin
          idx = k;
          if (pt[k+1] - pt[k] > 0) mu = ((pt[k+1] - x) * 256) / (pt[k+1] - pt[k]);
          break;
        end
      end
    end else if (x >= pt[6]) begin
      idx = 6;
    end
  endfunction

  function automatic longint gain_level(input logic [62:0] lv, input int u);
    return longint'((lv >> (9 * u)) & 63'h1FF);
  endfunction

  function automatic int weighted_gain(input bit is_kd, input logic [62:0] lv,
                                       input int pi, input int pm, input int di, input int dm);
    int p1, d1;
    longint acc;
    int r00, r10, r01, r11;
    p1 = pi < 6 ? pi + 1 : 6;
    d1 = di < 6 ? di + 1 : 6;
    r00 = is_kd ? fpsc_pkg::kd_rule(3'(pi), 3'(di)) : fpsc_pkg::kp_rule(3'(pi), 3'(di));
    r10 = is_kd ? fpsc_pkg::kd_rule(3'(p1), 3'(di)) : fpsc_pkg::kp_rule(3'(p1), 3'(di));
    r01 = is_kd ? fpsc_pkg::kd_rule(3'(pi), 3'(d1)) : fpsc_pkg::kp_rule(3'(pi), 3'(d1));
    r11 = is_kd ? fpsc_pkg::kd_rule(3'(p1), 3'(d1)) : fpsc_pkg::kp_rule(3'(p1), 3'(d1));
    acc = gain_level(lv, r00) * dm * pm + gain_level(lv, r10) * dm * (256 - pm)
        + gain_level(lv, r01) * (256 - dm) * pm + gain_level(lv, r11) * (256 - dm) * (256 - pm);
    return int'((acc + 32768) >>> 16);
  endfunction

  function automatic tb_steer_pkg::steer_result_t steer_predict(
      input logic signed [fpsc_pkg::ErrW-1:0] e_in, input logic [fpsc_pkg::ModeW-1:0] mode);
    int signed e, diff, dcl, pp[7], dp[7];
    int pi, di, pm, dm, kp, kd, kpx, kdx;
    longint term, v, servo;
    tb_steer_pkg::steer_result_t r;
    e = e_in;
    if (e > fpsc_pkg::ErrorLimit * 16) e = fpsc_pkg::ErrorLimit * 16;
    if (e < -fpsc_pkg::ErrorLimit * 16) e = -fpsc_pkg::ErrorLimit * 16;
    diff = e - prev_err;
    dcl = diff;
    if (dcl > fpsc_pkg::DerivLimit * 16) dcl = fpsc_pkg::DerivLimit * 16;
    if (dcl < -fpsc_pkg::DerivLimit * 16) dcl = -fpsc_pkg::DerivLimit * 16;
    bp_points(p_bp_reg, pp);
    bp_points(d_bp_reg, dp);
    membership(e, pp, pi, pm);
    membership(dcl, dp, di, dm);
    kp = weighted_gain(0, kp_lv_reg, pi, pm, di, dm);
    kd = weighted_gain(1, kd_lv_reg, pi, pm, di, dm);
    kpx = kp;
    kdx = kd;
    case (mode)
      fpsc_pkg::MODE_RING_RUN: kpx += int'(extra_reg[7:0]) * 16;
      fpsc_pkg::MODE_RING_OUT: kpx += 15 * 16;
      fpsc_pkg::MODE_RING_IN: kpx += int'(extra_reg[15:8]) * 16;
      fpsc_pkg::MODE_OBSTACLE: begin
        kpx += int'(extra_reg[23:16]) * 16;
        kdx += 16;
      end
      fpsc_pkg::MODE_PARKING: kpx += 3 * 16;
      default: ;
    endcase
    prev_err = e;
    term = longint'(e) * kpx + longint'(diff) * kdx;
    if (term > fpsc_pkg::DiffLimit * 256) term = fpsc_pkg::DiffLimit * 256;
    if (term < -fpsc_pkg::DiffLimit * 256) term = -fpsc_pkg::DiffLimit * 256;
    v = longint'(fpsc_pkg::ServoMid) * 256 - term;
    servo = v < 0 ? 0 : v / 256;
    if (servo > 65535) servo = 65535;
    if (servo > fpsc_pkg::ServoMax) servo = fpsc_pkg::ServoMax;
    if (servo < fpsc_pkg::ServoMin) servo = fpsc_pkg::ServoMin;
    r.servo_pwm = servo[15:0];
    r.steer_command = fpsc_pkg::CmdW'((longint'(r.servo_pwm) * 66) / 10);
    r.kp_gain = kp[8:0];
    r.kd_gain = kd[8:0];
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && $urandom_range(99) < 22;
  endfunction

  task automatic cfg_write(input logic [fpsc_pkg::CfgIdxW-1:0] idx,
                           input logic [fpsc_pkg::CfgDataW-1:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    case (idx)
      fpsc_pkg::CFG_P_BP: p_bp_reg = val[23:0];
      fpsc_pkg::CFG_D_BP: d_bp_reg = val[23:0];
      fpsc_pkg::CFG_KP_LV: kp_lv_reg = val;
      fpsc_pkg::CFG_KD_LV: kd_lv_reg = val;
      fpsc_pkg::CFG_MODE_G: extra_reg = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_all();
    in_ch.valid <= 0;
    while (steer_expected.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // send one word, gaps drawn before it
  task automatic send_word(input logic signed [fpsc_pkg::ErrW-1:0] e,
                           input logic [fpsc_pkg::ModeW-1:0] m);
    if (idle_now()) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.steer_error <= e;
    in_ch.drive_mode <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    steer_expected.push_back(steer_predict(e, m));
  endtask

  function automatic logic [62:0] rand_levels();
    return 63'({$urandom(), $urandom()} & 64'h7FFF_FFFF_FFFF_FFFF);
  endfunction

  // result side
  always @(posedge clk) begin
    tb_steer_pkg::steer_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (steer_expected.size() == 0) begin
        $error("unexpected result word");
        fail_seen = 1;
      end else begin
        exp_r = steer_expected.pop_front();
        if (out_ch.servo_pwm !== exp_r.servo_pwm) begin
          $error("servo_pwm exp %0d got %0d", exp_r.servo_pwm, out_ch.servo_pwm);
          fail_seen = 1;
        end
        if (out_ch.steer_command !== exp_r.steer_command) begin
          $error("steer_command exp %0d got %0d", exp_r.steer_command, out_ch.steer_command);
          fail_seen = 1;
        end
        if (out_ch.kp_gain !== exp_r.kp_gain) begin
          $error("kp_gain exp %0d got %0d", exp_r.kp_gain, out_ch.kp_gain);
          fail_seen = 1;
        end
        if (out_ch.kd_gain !== exp_r.kd_gain) begin
          $error("kd_gain exp %0d got %0d", exp_r.kd_gain, out_ch.kd_gain);
          fail_seen = 1;
        end
      end
    end
    out_ch.ready <= !hold_out && !idle_now();
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  stim_row_t dir_rows[] = '{
    '{12'sd0, 3'd0, 1, 16'd1500, 9'd0, 9'd0},
    '{12'sd2047, 3'd0, 1, 16'd1500, 9'd0, 9'd0},
    '{12'sh800, 3'd0, 1, 16'd1500, 9'd0, 9'd0},
    '{12'sd100, fpsc_pkg::MODE_RING_RUN, 0, 0, 0, 0},
    '{-12'sd100, fpsc_pkg::MODE_RING_OUT, 0, 0, 0, 0},
    '{12'sd576, fpsc_pkg::MODE_RING_IN, 0, 0, 0, 0},
    '{-12'sd576, fpsc_pkg::MODE_OBSTACLE, 0, 0, 0, 0},
    '{12'sd160, fpsc_pkg::MODE_PARKING, 0, 0, 0, 0},
    '{12'sd5, 3'd6, 0, 0, 0, 0},
    '{-12'sd5, 3'd7, 0, 0, 0, 0},
    '{12'sd320, 3'd2, 0, 0, 0, 0},
    '{12'sd0, 3'd4, 0, 0, 0, 0}
  };

  initial begin
    int hold;
    in_ch.valid = 0;
    in_ch.steer_error = 0;
    in_ch.drive_mode = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = fpsc_pkg::CFG_P_BP;
    cfg_ch.data = 0;
    out_ch.ready = 0;
    p_bp_reg = 24'd660516;
    d_bp_reg = 24'd330255;
    kp_lv_reg = 0;
    kd_lv_reg = 0;
    extra_reg = 24'd7680;
    prev_err = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // defaults: zero levels, fixed rows known at a glance
    for (int i = 0; i < 3; i++) begin
      send_word(dir_rows[i].err, dir_rows[i].mode);
      if (dir_rows[i].known) begin
        steer_expected[$].servo_pwm = dir_rows[i].servo;
        steer_expected[$].steer_command = fpsc_pkg::CmdW'(dir_rows[i].servo * 66 / 10);
        steer_expected[$].kp_gain = dir_rows[i].kp;
        steer_expected[$].kd_gain = dir_rows[i].kd;
      end
    end
    drain_all();
    cfg_write(fpsc_pkg::CFG_KP_LV, 63'h7FFF_FFFF_FFFF_FFFF);
    cfg_write(fpsc_pkg::CFG_KD_LV, 63'h7FFF_FFFF_FFFF_FFFF);
    cfg_write(fpsc_pkg::CFG_MODE_G, 24'hFFFFFF);
    for (int i = 0; i < dir_rows.size(); i++) send_word(dir_rows[i].err, dir_rows[i].mode);
    drain_all();
    cfg_write(fpsc_pkg::CFG_P_BP, 24'h000000);
    cfg_write(fpsc_pkg::CFG_D_BP, 24'hFFFFFF);
    for (int i = 3; i < dir_rows.size(); i++) send_word(dir_rows[i].err, dir_rows[i].mode);
    drain_all();
    cfg_write(fpsc_pkg::CFG_P_BP, 24'h0A1424);
    cfg_write(fpsc_pkg::CFG_D_BP, 24'h050A0F);

    for (int phase = 0; phase < 6; phase++) begin
      drain_all();
      if (phase > 0) begin
        cfg_write(fpsc_pkg::CFG_P_BP, phase == 3 ? 24'h30_10_05 : {8'($urandom_range(1, 40)),
                  8'($urandom_range(1, 40)), 8'($urandom_range(1, 40))});
        cfg_write(fpsc_pkg::CFG_D_BP, {8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)),
                  8'($urandom_range(1, 20))});
        cfg_write(fpsc_pkg::CFG_KP_LV, rand_levels());
        cfg_write(fpsc_pkg::CFG_KD_LV, rand_levels());
        cfg_write(fpsc_pkg::CFG_MODE_G, 24'($urandom()));
      end
      no_idle = (phase == 2);
      if (phase == 4) begin
        fork
          begin
            hold_out = 1;
            repeat (300) @(posedge clk);
            hold_out = 0;
          end
        join_none
      end
      for (int n = 0; n < 125; n++) begin
        hold = $urandom_range(9);
        if (hold < 2) send_word(12'($urandom()), 3'($urandom()));
        else send_word(12'($urandom_range(0, 1200)) - 12'sd600, 3'($urandom_range(0, 5)));
        if (n == 60) drain_all();
      end
    end
    no_idle = 0;
    drain_all();
    if (!fail_seen && steer_expected.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
